// ----- sv/msp_pkg.sv -----
// ----------------------------------------------------------------------------
// msp_pkg
// Shared types, constants and helpers for the motor speed PID regulator.
// ----------------------------------------------------------------------------
`default_nettype none

package msp_pkg;

    // Field widths
    localparam int SpeedW   = 12;
    localparam int TrimW    = 12;
    localparam int GainW    = 16;
    localparam int DriveW   = 11;
    localparam int AdjW     = 14;   // adjusted target, signed
    localparam int ErrW     = 16;   // error, signed
    localparam int SumW     = 17;   // error sum / difference, signed
    localparam int ProdW    = 34;   // 17 x 17 signed product
    localparam int AccW     = 37;   // negated weighted sum
    localparam int QuotW    = AccW - 8;

    // APB register map
    localparam int PaddrW   = 5;
    localparam logic [2:0] REG_TARGET = 3'd0;
    localparam logic [2:0] REG_TRIM   = 3'd1;
    localparam logic [2:0] REG_KP     = 3'd2;
    localparam logic [2:0] REG_KI     = 3'd3;
    localparam logic [2:0] REG_KD     = 3'd4;

    // Reset values
    localparam logic [GainW-1:0] KP_RESET = 16'd17920;
    localparam logic [GainW-1:0] KI_RESET = 16'd77;
    localparam logic [GainW-1:0] KD_RESET = 16'd12800;
    // target 0, trim 0: 0 + 11 - 2
    localparam logic signed [AdjW-1:0] ADJ_RESET = 14'sd9;

    localparam logic signed [AdjW-1:0] TARGET_BIAS = 14'sd11;

    localparam logic signed [QuotW-1:0] DRIVE_MAX = 29'sd2000;
    localparam logic signed [QuotW-1:0] DRIVE_MIN = 29'sd570;

    typedef struct packed {
        logic signed [AdjW-1:0] adj_target;
        logic [GainW-1:0]       kp;
        logic [GainW-1:0]       ki;
        logic [GainW-1:0]       kd;
    } msp_cfg_t;

    // Piecewise correction by range of the biased target
    function automatic logic signed [AdjW-1:0] range_offset(
        input logic signed [AdjW-1:0] s
    );
        logic signed [AdjW-1:0] r;
        if (s <= 14'sd480)
            r = -14'sd2;
        else if (s <= 14'sd650)
            r = -14'sd1;
        else if (s <= 14'sd700)
            r = 14'sd4;
        else if (s <= 14'sd800)
            r = 14'sd8;
        else if (s <= 14'sd1000)
            r = 14'sd12;
        else if (s <= 14'sd1100)
            r = 14'sd20;
        else
            r = 14'sd8;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/msp_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// msp_cfg_regs
// APB register file; also keeps the range-corrected target in a register.
// ----------------------------------------------------------------------------
`default_nettype none

module msp_cfg_regs
    import msp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [PaddrW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    output msp_cfg_t               cfg
);

    logic [SpeedW-1:0]      target_reg;
    logic [TrimW-1:0]       trim_reg;
    logic [GainW-1:0]       kp_reg;
    logic [GainW-1:0]       ki_reg;
    logic [GainW-1:0]       kd_reg;
    logic signed [AdjW-1:0] adj_reg;
    logic signed [AdjW-1:0] adj_biased;
    logic signed [AdjW-1:0] adj_next;
    logic                   wr_en;
    logic [2:0]             idx;

    assign pready = 1'b1;
    assign idx    = paddr[PaddrW-1:2];
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            trim_reg   <= '0;
            kp_reg     <= KP_RESET;
            ki_reg     <= KI_RESET;
            kd_reg     <= KD_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_TARGET: target_reg <= pwdata[SpeedW-1:0];
                REG_TRIM:   trim_reg   <= pwdata[TrimW-1:0];
                REG_KP:     kp_reg     <= pwdata[GainW-1:0];
                REG_KI:     ki_reg     <= pwdata[GainW-1:0];
                REG_KD:     kd_reg     <= pwdata[GainW-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_TARGET: prdata = {{(32-SpeedW){1'b0}}, target_reg};
            REG_TRIM:   prdata = {{(32-TrimW){1'b0}}, trim_reg};
            REG_KP:     prdata = {{(32-GainW){1'b0}}, kp_reg};
            REG_KI:     prdata = {{(32-GainW){1'b0}}, ki_reg};
            REG_KD:     prdata = {{(32-GainW){1'b0}}, kd_reg};
            default:    prdata = '0;
        endcase
    end

    // target + 11 + trim, then the range correction
    assign adj_biased = $signed({{(AdjW-SpeedW){1'b0}}, target_reg}) + TARGET_BIAS
                      + $signed({{(AdjW-TrimW){trim_reg[TrimW-1]}}, trim_reg});
    assign adj_next   = adj_biased + range_offset(adj_biased);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            adj_reg <= ADJ_RESET;
        else
            adj_reg <= adj_next;
    end

    assign cfg.adj_target = adj_reg;
    assign cfg.kp         = kp_reg;
    assign cfg.ki         = ki_reg;
    assign cfg.kd         = kd_reg;

endmodule

`default_nettype wire

// ----- sv/msp_datapath.sv -----
// ----------------------------------------------------------------------------
// msp_datapath
// Five-register PID pipeline: input, error terms, products, sum, drive.
// ----------------------------------------------------------------------------
`default_nettype none

module msp_datapath
    import msp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire msp_cfg_t          cfg,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [SpeedW-1:0] in_speed,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [DriveW-1:0]      out_drive
);

    // stage valids
    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy0, rdy1, rdy2, rdy3, rdy4;

    // payload
    logic [SpeedW-1:0]       meas_reg;
    logic signed [ErrW-1:0]  prev_err_reg;
    logic signed [ErrW-1:0]  err_next;
    logic signed [SumW-1:0]  err_reg, sum_reg, diff_reg;
    logic signed [SumW-1:0]  sum_next, diff_next;
    logic signed [ProdW-1:0] pp_reg, pi_reg, pd_reg;
    logic signed [AccW-1:0]  neg_reg, neg_next;
    logic signed [AccW-1:0]  rnd;
    logic signed [QuotW-1:0] quot;
    logic [DriveW-1:0]       drive_reg, drive_next;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign rdy0     = !v0_reg || rdy1;
    assign in_ready = rdy0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy0)
                v0_reg <= in_valid;
            if (rdy1)
                v1_reg <= v0_reg;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
        end
    end

    // error terms; previous error moves with the item into stage 1
    assign err_next  = $signed({{(ErrW-SpeedW){1'b0}}, meas_reg})
                     - $signed({{(ErrW-AdjW){cfg.adj_target[AdjW-1]}}, cfg.adj_target});
    assign sum_next  = $signed({err_next[ErrW-1], err_next})
                     + $signed({prev_err_reg[ErrW-1], prev_err_reg});
    assign diff_next = $signed({err_next[ErrW-1], err_next})
                     - $signed({prev_err_reg[ErrW-1], prev_err_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prev_err_reg <= '0;
        else if (rdy1 && v0_reg)
            prev_err_reg <= err_next;
    end

    // negated weighted sum
    assign neg_next = -($signed({{(AccW-ProdW){pp_reg[ProdW-1]}}, pp_reg})
                      + $signed({{(AccW-ProdW){pi_reg[ProdW-1]}}, pi_reg})
                      + $signed({{(AccW-ProdW){pd_reg[ProdW-1]}}, pd_reg}));

    // divide by 256 toward zero, then clamp
    assign rnd  = neg_reg + (neg_reg[AccW-1] ? 37'sd255 : 37'sd0);
    assign quot = rnd[AccW-1:8];

    always_comb
    begin
        if (quot > DRIVE_MAX)
            drive_next = DRIVE_MAX[DriveW-1:0];
        else if (quot < DRIVE_MIN)
            drive_next = DRIVE_MIN[DriveW-1:0];
        else
            drive_next = quot[DriveW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (rdy0 && in_valid)
            meas_reg <= in_speed;
        if (rdy1 && v0_reg)
        begin
            err_reg  <= $signed({err_next[ErrW-1], err_next});
            sum_reg  <= sum_next;
            diff_reg <= diff_next;
        end
        if (rdy2 && v1_reg)
        begin
            pp_reg <= $signed({1'b0, cfg.kp}) * err_reg;
            pi_reg <= $signed({1'b0, cfg.ki}) * sum_reg;
            pd_reg <= $signed({1'b0, cfg.kd}) * diff_reg;
        end
        if (rdy3 && v2_reg)
            neg_reg <= neg_next;
        if (rdy4 && v3_reg)
            drive_reg <= drive_next;
    end

    assign out_valid = v4_reg;
    assign out_drive = drive_reg;

endmodule

`default_nettype wire

// ----- sv/motor_speed_pid_regulator_unit.sv -----
// ----------------------------------------------------------------------------
// motor_speed_pid_regulator_unit
// PID speed regulator: one measured speed sample in, one PWM drive value out.
// ----------------------------------------------------------------------------
//  channel   dir  signals                       contents
//  s_axis    in   s_tvalid/s_tready/s_tdata     [11:0] measured_speed
//  m_axis    out  m_tvalid/m_tready/m_tdata     [10:0] pwm_drive
//  apb       in   psel/penable/pwrite/paddr     regs at 0x00..0x10
//
//  One request accepted per cycle while the output is not stalled; the
//  input register loads at the accept edge, then error, multiply, sum and
//  clamp stages follow in that order.
//  Reset clears the previous error and loads default gains.
//  A stalled output holds its stage; upstream stages keep filling bubbles.
//  Gain writes reach the datapath at once; target and trim in the cycle after.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_speed_pid_regulator_unit
    import msp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [15:0]       s_tdata,   // [11:0] measured_speed
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [15:0]            m_tdata,   // [10:0] pwm_drive
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [PaddrW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    msp_cfg_t          cfg;
    logic [DriveW-1:0] drive;

    msp_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    msp_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_speed  (s_tdata[SpeedW-1:0]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_drive (drive)
    );

    assign m_tdata = {{(16-DriveW){1'b0}}, drive};

endmodule

`default_nettype wire

// ----- test/tb_motor_speed_pid_regulator_unit.sv -----
// ----------------------------------------------------------------------------
// tb_motor_speed_pid_regulator_unit
// Self-checking bench for the PID speed regulator. A short table of speed
// samples and register settings comes first: reset state, field extremes,
// zero and full-scale gains, a negative adjusted target and every range edge
// of the target correction. After it come random samples under random
// register settings and three patterns of stream backpressure. Each drive
// value is checked against the table or the regulator model in this file.
// ----------------------------------------------------------------------------
module tb_motor_speed_pid_regulator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import msp_pkg::*;

    localparam int LATENCY   = 5;
    localparam int SPEED_MAX = 4095;
    localparam int ROWS      = 22;
    localparam int BATCH     = 84;
    localparam int SETTINGS_PER_MODE = 5;
    localparam int USE_MODEL = -1;
    localparam logic [2:0] REG_SPARE = REG_KD + 3'd1;

    typedef struct {
        bit load_cfg;
        int target;
        int trim;
        int kp;
        int ki;
        int kd;
        int speed;
        int drive;      // USE_MODEL: take the model's value
    } speed_row_t;

    // range edges sit at target = edge - 11 with zero trim
    speed_row_t speed_rows [ROWS] = '{
        '{0,    0,     0, 17920,    77, 12800,    9, 570},
        '{0,    0,     0, 17920,    77, 12800,    0, USE_MODEL},
        '{0,    0,     0, 17920,    77, 12800, 4095, 570},
        '{0,    0,     0, 17920,    77, 12800,    0, 2000},
        '{0,    0,     0, 17920,    77, 12800, 4095, 570},
        '{1,    0,     0,     0,     0,     0, 4095, 570},
        '{1, 4095,  2047, 65535, 65535, 65535,    0, 2000},
        '{0, 4095,  2047, 65535, 65535, 65535, 4095, USE_MODEL},
        '{1,    0, -2048, 17920,    77, 12800,    0, USE_MODEL},
        '{0,    0, -2048, 17920,    77, 12800, 4095, USE_MODEL},
        '{1,  469,     0, 17920,    77, 12800,  470, USE_MODEL},
        '{1,  470,     0, 17920,    77, 12800,  471, USE_MODEL},
        '{1,  639,     0, 17920,    77, 12800,  640, USE_MODEL},
        '{1,  640,     0, 17920,    77, 12800,  641, USE_MODEL},
        '{1,  689,     0, 17920,    77, 12800,  690, USE_MODEL},
        '{1,  690,     0, 17920,    77, 12800,  691, USE_MODEL},
        '{1,  789,     0, 17920,    77, 12800,  790, USE_MODEL},
        '{1,  790,     0, 17920,    77, 12800,  791, USE_MODEL},
        '{1,  989,     0, 17920,    77, 12800,  990, USE_MODEL},
        '{1,  990,     0, 17920,    77, 12800,  991, USE_MODEL},
        '{1, 1089,     0, 17920,    77, 12800, 1090, USE_MODEL},
        '{1, 1090,     0, 17920,    77, 12800, 1091, USE_MODEL}
    };

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata  = '0;   // [11:0] measured_speed
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [15:0]       m_tdata;         // [10:0] pwm_drive
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [PaddrW-1:0] paddr    = '0;
    logic [31:0]       pwdata   = '0;
    logic [31:0]       prdata;
    logic              pready;

    // regulator model state
    logic [SpeedW-1:0]        set_speed  = '0;
    logic signed [TrimW-1:0]  speed_trim = '0;
    logic [GainW-1:0]         gain_p     = KP_RESET;
    logic [GainW-1:0]         gain_i     = KI_RESET;
    logic [GainW-1:0]         gain_d     = KD_RESET;
    int                       last_error = 0;

    logic [DriveW-1:0] drive_queue [$];
    int mismatches  = 0;
    int tx_idle_pct = 13;
    int rx_idle_pct = 85;

    motor_speed_pid_regulator_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int adjusted_target();
        int s;
        s = int'(set_speed) + int'(TARGET_BIAS) + int'(speed_trim);
        if (s <= 480)
            return s - 2;
        else if (s <= 650)
            return s - 1;
        else if (s <= 700)
            return s + 4;
        else if (s <= 800)
            return s + 8;
        else if (s <= 1000)
            return s + 12;
        else if (s <= 1100)
            return s + 20;
        return s + 8;
    endfunction

    // advances the stored error, so call once per accepted sample
    function automatic logic [DriveW-1:0] predict_drive(input logic [SpeedW-1:0] speed);
        int     err;
        int     err_sum;
        int     err_diff;
        longint acc;
        longint drive;
        err      = int'(speed) - adjusted_target();
        err_sum  = err + last_error;
        err_diff = err - last_error;
        acc = longint'(gain_p) * err + longint'(gain_d) * err_diff
            + longint'(gain_i) * err_sum;
        drive = (-acc) / 256;   // truncates toward zero
        last_error = err;
        if (drive > DRIVE_MAX)
            drive = DRIVE_MAX;
        if (drive < DRIVE_MIN)
            drive = DRIVE_MIN;
        return drive[DriveW-1:0];
    endfunction

    function automatic int pick_gain();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 0;
        if (r == 1)
            return 65535;
        return $urandom_range(0, 24000);
    endfunction

    // mostly just below the target so the drive stays off the clamp
    function automatic logic [SpeedW-1:0] pick_speed();
        int adj;
        int r;
        int v;
        adj = adjusted_target();
        r   = $urandom_range(0, 9);
        if (r < 7)
            v = adj - int'($urandom_range(0, 40));
        else if (r < 9)
            v = adj + int'($urandom_range(0, 400)) - 200;
        else
            v = int'($urandom_range(0, SPEED_MAX));
        if (v < 0)
            v = 0;
        if (v > SPEED_MAX)
            v = SPEED_MAX;
        return v[SpeedW-1:0];
    endfunction

    // leaves psel high; the caller closes the transfer series
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] wdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PaddrW'({idx, 2'b00});
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
    endtask

    task automatic apply_config(input int target, input int trim, input int kp,
                                input int ki, input int kd);
        apb_write(REG_TARGET, {20'd0, 12'(target)});
        apb_write(REG_TRIM,   {20'd0, 12'(trim)});
        apb_write(REG_KP,     {16'd0, 16'(kp)});
        apb_write(REG_KI,     {16'd0, 16'(ki)});
        apb_write(REG_KD,     {16'd0, 16'(kd)});
        // unmapped offset, must leave the regulator untouched
        apb_write(REG_SPARE + 3'($urandom_range(0, 2)), $urandom);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        set_speed  = 12'(target);
        speed_trim = 12'(trim);
        gain_p     = 16'(kp);
        gain_i     = 16'(ki);
        gain_d     = 16'(kd);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (drive_queue.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_speed(input logic [SpeedW-1:0] speed, input int drive);
        logic [DriveW-1:0] predicted;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, speed};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = predict_drive(speed);
        drive_queue.push_back((drive == USE_MODEL) ? predicted : DriveW'(drive));
    endtask

    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

    always @(posedge clk)
    begin : drive_check
        logic [DriveW-1:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (drive_queue.size() == 0)
            begin
                $error("pwm_drive: expected none, actual %0d", m_tdata[DriveW-1:0]);
                mismatches++;
            end
            else
            begin
                want = drive_queue.pop_front();
                if (m_tdata[DriveW-1:0] !== want)
                begin
                    $error("pwm_drive: expected %0d, actual %0d", want,
                           m_tdata[DriveW-1:0]);
                    mismatches++;
                end
            end
            if (m_tdata[15:DriveW] !== '0)
            begin
                $error("tdata pad: expected 0, actual %0h", m_tdata[15:DriveW]);
                mismatches++;
            end
        end
    end

    initial
    begin : stimulus
        int mode;
        int setting;
        int n;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (speed_rows[i])
        begin
            if (speed_rows[i].load_cfg)
            begin
                wait_drained();
                apply_config(speed_rows[i].target, speed_rows[i].trim, speed_rows[i].kp,
                             speed_rows[i].ki, speed_rows[i].kd);
            end
            send_speed(12'(speed_rows[i].speed), speed_rows[i].drive);
        end

        for (mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0: begin tx_idle_pct = 13; rx_idle_pct = 85; end
                1: begin tx_idle_pct = 85; rx_idle_pct = 13; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            for (setting = 0; setting < SETTINGS_PER_MODE; setting++)
            begin
                wait_drained();
                apply_config($urandom_range(0, SPEED_MAX),
                             int'($urandom_range(0, 4095)) - 2048,
                             pick_gain(), pick_gain(), pick_gain());
                for (n = 0; n < BATCH; n++)
                    send_speed(pick_speed(), USE_MODEL);
            end
        end

        wait_drained();
        repeat (LATENCY + 4) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
